// ===== rtl/core/kuznyechik_block_cipher_assert.svh =====
// assertion macros for the cipher checker
`ifndef KUZNYECHIK_BLOCK_CIPHER_ASSERT_SVH
`define KUZNYECHIK_BLOCK_CIPHER_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define KBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kbc check failed");

// antecedent holds -> consequent in the next cycle
`define KBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kbc check failed");

`endif

// ===== rtl/core/kbc_pkg.sv =====
`timescale 1ns / 1ps
package kbc_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int ROUNDS      = 9;
  localparam int SCHED_STEPS = 32;
  localparam int NUM_KEYS    = 10;

  typedef logic [BLOCK_BYTES-1:0][7:0] blk_t;
  typedef logic [0:255][7:0] sbox_t;
  typedef logic [0:15][0:15][7:0] mat_t;
  typedef logic [4:0] cnt_t;
  typedef logic [3:0] kidx_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
  } src_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYINIT,
    ST_KEYSCHED,
    ST_RUN
  } state_t;

  typedef enum logic [1:0] {
    REG_KEY0,
    REG_KEY1,
    REG_KEY2,
    REG_KEY3
  } reg_idx_t;

  typedef struct packed {
    logic  sched_init;
    logic  sched_step;
    logic  load;
    logic  round_step;
    logic  finish;
    cnt_t  cnt;
  } cmd_t;

  localparam sbox_t SBOX = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
    8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
    8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
    8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
    8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
    8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
    8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
    8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
    8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
    8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
    8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
    8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
    8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
    8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
    8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
    8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
    8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
  };

  localparam logic [0:15][7:0] LCOEF = '{
    8'd1,8'd148,8'd32,8'd133,8'd16,8'd194,8'd192,8'd1,
    8'd251,8'd1,8'd192,8'd194,8'd16,8'd133,8'd32,8'd148
  };

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = 8'd0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ 9'h1C3;
    end
    return acc;
  endfunction

  function automatic sbox_t build_inv_sbox();
    sbox_t s;
    s = '0;
    for (int i = 0; i < 256; i++) s[SBOX[i]] = i[7:0];
    return s;
  endfunction

  localparam sbox_t SBOX_INV = build_inv_sbox();

  // columns of L (or L inverse) from unit vectors
  function automatic mat_t build_mat(input logic inv);
    mat_t m;
    logic [0:15][7:0] b;
    logic [7:0] t;
    m = '0;
    for (int c = 0; c < 16; c++) begin
      b = '0;
      b[c] = 8'd1;
      for (int n = 0; n < 16; n++) begin
        if (!inv) begin
          t = b[0];
          for (int i = 1; i < 16; i++) begin
            t = t ^ gf_mul(LCOEF[i], b[i]);
            b[i-1] = b[i];
          end
          b[15] = t;
        end else begin
          t = b[15];
          for (int i = 14; i >= 0; i--) begin
            t = t ^ gf_mul(LCOEF[i+1], b[i]);
            b[i+1] = b[i];
          end
          b[0] = t;
        end
      end
      for (int j = 0; j < 16; j++) m[j][c] = b[j];
    end
    return m;
  endfunction

  localparam mat_t LMAT     = build_mat(1'b0);
  localparam mat_t LMAT_INV = build_mat(1'b1);

  function automatic blk_t lin(input mat_t m, input blk_t b);
    blk_t o;
    o = '0;
    for (int j = 0; j < 16; j++)
      for (int i = 0; i < 16; i++) o[j] = o[j] ^ gf_mul(m[j][i], b[i]);
    return o;
  endfunction

  function automatic blk_t sub_fwd(input blk_t b);
    blk_t o;
    for (int i = 0; i < 16; i++) o[i] = SBOX[b[i]];
    return o;
  endfunction

  function automatic blk_t sub_inv(input blk_t b);
    blk_t o;
    for (int i = 0; i < 16; i++) o[i] = SBOX_INV[b[i]];
    return o;
  endfunction

  // schedule constant C(s+1) = L applied to byte 0 = s+1
  function automatic blk_t sched_const(input cnt_t s);
    blk_t o;
    logic [7:0] v;
    v = {3'b000, s} + 8'd1;
    for (int j = 0; j < 16; j++) o[j] = gf_mul(LMAT[j][0], v);
    return o;
  endfunction

endpackage

// ===== rtl/core/kuznyechik_block_cipher.sv =====
`timescale 1ns / 1ps
// After a start beat is accepted the block is loaded, the rounds run in ST_RUN, then done.
// A new block is accepted only back in idle, once the previous one finishes; busy is high meanwhile.
// Key schedule: after reset or a key write, busy stays high while ST_KEYINIT and ST_KEYSCHED run.
// Reset (rst, synchronous): key words clear to zero, schedule rebuilt.
// done is a single-cycle strobe; the receiver cannot stall.
module kuznyechik_block_cipher (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  kbc_pkg::src_t src,
  output logic          done,
  output kbc_pkg::res_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  kbc_pkg::cmd_t     cmd;
  logic              key_wr;
  kbc_pkg::reg_idx_t key_sel;
  logic [3:0][63:0]  key_words;

  assign pready  = 1'b1;
  assign key_wr  = psel && penable && pwrite;
  assign key_sel = kbc_pkg::reg_idx_t'(paddr[4:3]);
  assign prdata  = key_words[key_sel];

  kbc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .key_wr (key_wr),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  kbc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .src       (src),
    .key_wr    (key_wr),
    .key_sel   (key_sel),
    .key_data  (pwdata),
    .key_words (key_words),
    .result    (result)
  );

endmodule

// ===== rtl/core/kbc_ctrl.sv =====
`timescale 1ns / 1ps
module kbc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          key_wr,
  output logic          busy,
  output logic          done,
  output kbc_pkg::cmd_t cmd
);

  kbc_pkg::state_t state, state_next;
  kbc_pkg::cnt_t   cnt;
  logic            rekey;
  logic            accept;

  assign busy   = (state != kbc_pkg::ST_IDLE) || rekey;
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      kbc_pkg::ST_IDLE: begin
        if (rekey) state_next = kbc_pkg::ST_KEYINIT;
        else if (start) state_next = kbc_pkg::ST_RUN;
      end
      kbc_pkg::ST_KEYINIT: state_next = kbc_pkg::ST_KEYSCHED;
      kbc_pkg::ST_KEYSCHED: begin
        if (cnt == kbc_pkg::cnt_t'(kbc_pkg::SCHED_STEPS - 1)) state_next = kbc_pkg::ST_IDLE;
      end
      kbc_pkg::ST_RUN: begin
        if (cnt == kbc_pkg::cnt_t'(kbc_pkg::ROUNDS)) state_next = kbc_pkg::ST_IDLE;
      end
      default: state_next = kbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.cnt = cnt;
    unique case (state)
      kbc_pkg::ST_IDLE:     cmd.load = accept;
      kbc_pkg::ST_KEYINIT:  cmd.sched_init = 1'b1;
      kbc_pkg::ST_KEYSCHED: cmd.sched_step = 1'b1;
      kbc_pkg::ST_RUN: begin
        cmd.round_step = (cnt != kbc_pkg::cnt_t'(kbc_pkg::ROUNDS));
        cmd.finish     = (cnt == kbc_pkg::cnt_t'(kbc_pkg::ROUNDS));
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kbc_pkg::ST_KEYINIT;
      cnt   <= '0;
      rekey <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
      if (state != state_next) cnt <= '0;
      else cnt <= cnt + 5'd1;
      if (key_wr) rekey <= 1'b1;
      else if (state == kbc_pkg::ST_KEYINIT) rekey <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/kbc_datapath.sv =====
`timescale 1ns / 1ps
module kbc_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  kbc_pkg::cmd_t             cmd,
  input  kbc_pkg::src_t             src,
  input  logic                      key_wr,
  input  kbc_pkg::reg_idx_t         key_sel,
  input  logic [63:0]               key_data,
  output logic [3:0][63:0]          key_words,
  output kbc_pkg::res_t             result
);

  logic [3:0][63:0] kw;
  kbc_pkg::blk_t    rk [kbc_pkg::NUM_KEYS];
  kbc_pkg::blk_t    sr, sl, x;
  logic             mode_q;
  kbc_pkg::kidx_t   kidx, widx;
  kbc_pkg::blk_t    key, fwd_in, fwd_key, fwd_out, inv_out, sr_next;

  assign key_words = kw;

  assign kidx = mode_q ? (4'd9 - cmd.cnt[3:0]) : cmd.cnt[3:0];
  assign key  = rk[kidx];

  assign fwd_in  = cmd.sched_step ? sr : x;
  assign fwd_key = cmd.sched_step ? kbc_pkg::sched_const(cmd.cnt) : key;
  assign fwd_out = kbc_pkg::lin(kbc_pkg::LMAT, kbc_pkg::sub_fwd(fwd_in ^ fwd_key));
  assign inv_out = kbc_pkg::sub_inv(kbc_pkg::lin(kbc_pkg::LMAT_INV, x ^ key));
  assign sr_next = fwd_out ^ sl;
  assign widx    = {1'b0, cmd.cnt[4:3], 1'b0} + 4'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      kw <= '0;
    end else if (key_wr) begin
      kw[key_sel] <= key_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched_init) begin
      rk[0] <= {kw[kbc_pkg::REG_KEY3], kw[kbc_pkg::REG_KEY2]};
      rk[1] <= {kw[kbc_pkg::REG_KEY1], kw[kbc_pkg::REG_KEY0]};
      sr    <= {kw[kbc_pkg::REG_KEY3], kw[kbc_pkg::REG_KEY2]};
      sl    <= {kw[kbc_pkg::REG_KEY1], kw[kbc_pkg::REG_KEY0]};
    end
    if (cmd.sched_step) begin
      sr <= sr_next;
      sl <= sr;
      if (cmd.cnt[2:0] == 3'd7) begin
        rk[widx]        <= sr_next;
        rk[widx + 4'd1] <= sr;
      end
    end
    if (cmd.load) begin
      x      <= {src.data_hi, src.data_lo};
      mode_q <= src.mode;
    end
    if (cmd.round_step) x <= mode_q ? inv_out : fwd_out;
    if (cmd.finish) result <= x ^ key;
  end

endmodule

// ===== rtl/core/kbc_checker.sv =====
`timescale 1ns / 1ps
`include "kuznyechik_block_cipher_assert.svh"
module kbc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `KBC_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  `KBC_ASSERT_NOW(a_done_latency, start && !busy, ##11 done)
  `KBC_ASSERT_NEXT(a_done_single, done, !done)
  `KBC_ASSERT_NOW(a_done_after_busy, done, $past(busy))

endmodule

bind kuznyechik_block_cipher kbc_checker u_kbc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== dv/kbc_checker.sv =====
`timescale 1ns / 1ps
module kbc_scoreboard (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  kbc_pkg::src_t src,
  input  logic          done,
  input  kbc_pkg::res_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  input  logic          pready,
  output int            errors,
  output int            pending
);

  typedef logic [15:0][7:0] block_t;

  localparam logic [0:255][7:0] PI = '{
    252,238,221,17,207,110,49,22,251,196,250,218,35,197,4,77,
    233,119,240,219,147,46,153,186,23,54,241,187,20,205,95,193,
    249,24,101,90,226,92,239,33,129,28,60,66,139,1,142,79,
    5,132,2,174,227,106,143,160,6,11,237,152,127,212,211,31,
    235,52,44,81,234,200,72,171,242,42,104,162,253,58,206,204,
    181,112,14,86,8,12,118,18,191,114,19,71,156,183,93,135,
    21,161,150,41,16,123,154,199,243,145,120,111,157,158,178,177,
    50,117,25,61,255,53,138,126,109,84,198,128,195,189,13,87,
    223,245,36,169,62,168,67,201,215,121,214,246,124,34,185,3,
    224,15,236,222,122,148,176,188,220,232,40,80,78,51,10,74,
    167,151,96,115,30,0,98,68,26,184,56,130,100,159,38,65,
    173,69,70,146,39,94,85,47,140,163,165,125,105,213,149,59,
    7,88,179,64,134,172,29,247,48,55,107,228,136,217,231,137,
    225,27,131,73,76,63,248,254,141,83,170,144,202,216,133,97,
    32,113,103,164,45,43,9,91,203,155,37,208,190,229,108,82,
    89,166,116,210,230,244,180,192,209,102,175,194,57,75,99,182
  };
  localparam logic [0:15][7:0] COEF = '{
    1,148,32,133,16,194,192,1,251,1,192,194,16,133,32,148
  };

  logic [7:0]    pi_inv [256];
  block_t        sched_c [32];
  block_t        rkey [10];
  logic [63:0]   kw [4];
  kbc_pkg::res_t blocks_due [$];

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x = {1'b0, a};
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x[7:0];
      x = x << 1;
      if (x[8]) x ^= 9'h1C3;
    end
    return acc;
  endfunction

  function automatic block_t mix(block_t b);
    logic [7:0] t;
    for (int n = 0; n < 16; n++) begin
      t = b[0];
      for (int i = 1; i < 16; i++) begin
        t ^= gmul(COEF[i], b[i]);
        b[i-1] = b[i];
      end
      b[15] = t;
    end
    return b;
  endfunction

  function automatic block_t unmix(block_t b);
    logic [7:0] t;
    for (int n = 0; n < 16; n++) begin
      t = b[15];
      for (int i = 14; i >= 0; i--) begin
        t ^= gmul(COEF[i+1], b[i]);
        b[i+1] = b[i];
      end
      b[0] = t;
    end
    return b;
  endfunction

  function automatic block_t subst(block_t b, bit inv);
    for (int i = 0; i < 16; i++) b[i] = inv ? pi_inv[b[i]] : PI[b[i]];
    return b;
  endfunction

  function automatic void expand_keys();
    block_t r, l, t;
    r = {kw[3], kw[2]};
    l = {kw[1], kw[0]};
    rkey[0] = r;
    rkey[1] = l;
    for (int s = 0; s < 32; s++) begin
      t = mix(subst(r ^ sched_c[s], 1'b0)) ^ l;
      l = r;
      r = t;
      if (s % 8 == 7) begin
        rkey[2 + 2 * (s / 8)] = r;
        rkey[3 + 2 * (s / 8)] = l;
      end
    end
  endfunction

  function automatic kbc_pkg::res_t cipher(kbc_pkg::src_t s);
    block_t b;
    b = {s.data_hi, s.data_lo};
    if (!s.mode) begin
      for (int r = 0; r < 9; r++) b = mix(subst(b ^ rkey[r], 1'b0));
      b ^= rkey[9];
    end else begin
      for (int r = 9; r > 0; r--) b = subst(unmix(b ^ rkey[r]), 1'b1);
      b ^= rkey[0];
    end
    return '{result_hi: b[15:8], result_lo: b[7:0]};
  endfunction

  initial begin
    block_t b;
    errors = 0;
    for (int i = 0; i < 256; i++) pi_inv[PI[i]] = i[7:0];
    for (int i = 0; i < 32; i++) begin
      b = '0;
      b[0] = 8'(i + 1);
      sched_c[i] = mix(b);
    end
    for (int i = 0; i < 4; i++) kw[i] = '0;
    expand_keys();
  end

  assign pending = blocks_due.size();

  always @(posedge clk) begin
    kbc_pkg::res_t want;
    if (rst) begin
      blocks_due.delete();
      for (int i = 0; i < 4; i++) kw[i] = '0;
      expand_keys();
    end else begin
      if (done) begin
        if (blocks_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected result beat %h", $realtime, result);
        end else begin
          want = blocks_due.pop_front();
          if (result.result_lo !== want.result_lo || result.result_hi !== want.result_hi) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp hi=%h lo=%h got hi=%h lo=%h", $realtime,
                       want.result_hi, want.result_lo, result.result_hi, result.result_lo);
          end
        end
      end
      if (start && !busy) blocks_due = {blocks_due, cipher(src)};
      if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0) begin
        kw[paddr[4:3]] = pwdata;
        expand_keys();
      end
    end
  end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  logic          clk = 0;
  logic          rst = 1;
  logic          start = 0;
  logic          busy;
  kbc_pkg::src_t src = '0;
  logic          done;
  kbc_pkg::res_t result;
  logic          psel = 0, penable = 0, pwrite = 0;
  logic [4:0]    paddr = '0;
  logic [63:0]   pwdata = '0;
  logic [63:0]   prdata;
  logic          pready;
  int            errors, pending;
  int            idle_pct = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  kuznyechik_block_cipher dut (.*);

  kbc_scoreboard chk (.*);

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  task automatic send_block(logic m, logic [63:0] lo, logic [63:0] hi);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
    start = 1;
    src = '{mode: m, data_hi: hi, data_lo: lo};
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    while (pending != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  task automatic write_key(kbc_pkg::reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic load_key(logic [63:0] k0, k1, k2, k3);
    drain();
    write_key(kbc_pkg::REG_KEY0, k0);
    write_key(kbc_pkg::REG_KEY1, k1);
    write_key(kbc_pkg::REG_KEY2, k2);
    write_key(kbc_pkg::REG_KEY3, k3);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_blocks(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      send_block(1'($urandom_range(1)), rnd64(), rnd64());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // zero key after reset
    for (int m = 0; m < 2; m++) begin
      send_block(1'(m), '0, '0);
      send_block(1'(m), '1, '1);
      send_block(1'(m), 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_block(1'(m), 64'h1122_3344_5566_7700, 64'hFFEE_DDCC_BBAA_9988);
      send_block(1'(m), 64'h1, 64'h8000_0000_0000_0000);
    end
    load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
             64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
    for (int m = 0; m < 2; m++) begin
      send_block(1'(m), 64'h1122_3344_5566_7700, 64'hFFEE_DDCC_BBAA_9988);
      send_block(1'(m), 64'h7F67_9D90_BEBC_2430, 64'h5A46_8D42_B9D4_EDCD);
      send_block(1'(m), '1, '0);
      send_block(1'(m), '0, '1);
    end

    load_key('1, '1, '1, '1);
    idle_pct = 65;
    random_blocks(110);

    load_key(64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
             64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF);
    idle_pct = 7;
    random_blocks(110);

    load_key(rnd64(), rnd64(), rnd64(), rnd64());
    idle_pct = 0;
    random_blocks(110);

    load_key('0, '0, '0, '0);
    idle_pct = 65;
    random_blocks(110);

    drain();
    if (errors == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
